// File: rtl/core/pip_pkg.sv
// Package for the even-odd point-in-polygon block.
// Holds the item action codes, the sequencer states and the orientation sign codes.
// Depends on nothing; the top level of the block imports it.
package pip_pkg;

   localparam int ACTION_W = 2;
   localparam int CROSS_W  = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_MUL_P,
      ST_MUL_QA,
      ST_MUL_QB,
      ST_WAIT,
      ST_EVAL,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      ORI_ZERO,
      ORI_POS,
      ORI_NEG
   } orient_type;

endpackage

// File: rtl/core/pip_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the polygon vertex store; depends on no other file.
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/pip_mul.sv
// Shared signed multiplier with registered operands and a registered product.
// The product is registered behind the operand registers; depends on no other file.
module pip_mul #(
   parameter int W = 18
) (
   input  logic                  clock,
   input  logic signed [W-1:0]   op_a,
   input  logic signed [W-1:0]   op_b,
   output logic signed [2*W-1:0] prod
);

   logic signed [W-1:0]   a_ff;
   logic signed [W-1:0]   b_ff;
   logic signed [2*W-1:0] prod_ff;
   logic signed [2*W-1:0] prod_in;

   assign prod_in = a_ff * b_ff;

   always_ff @(posedge clock) begin
      a_ff    <= op_a;
      b_ff    <= op_b;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: rtl/core/point_in_polygon_even_odd.sv
// Top level of the even-odd point-in-polygon block.
// Depends on pip_pkg, pip_ram (vertex store) and pip_mul (shared multiplier).
//
// Usage: an item is taken at a rising edge with start high and busy low.
// A clear item empties the polygon and clears the overflow flag. An append item
// writes one vertex into the store and tracks the lowest Y; when the store is
// full the vertex is dropped and the sticky overflow flag is set. Clear and
// append never raise busy, so items of those kinds can follow each other on
// every cycle. A query item raises busy and walks the stored edges, wrap edge
// included, against a vertical segment from the point down to the lowest Y
// minus the margin. For each edge its vertices are read from the store as needed
// (the wrap edge reuses the first one) and three products pass through the single
// shared multiplier, which registers its operands and its product. rsp_strobe
// marks the one result cycle at the end of the query. The receiver cannot
// stall, so the result is shown once and busy then drops. Reset empties the
// polygon and clears the overflow flag and the sequencer.
module point_in_polygon_even_odd #(
   parameter int MAX_VERTICES = 64,
   parameter int RAY_MARGIN   = 5,
   parameter int COORD_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pip_pkg::ACTION_W-1:0]         req_action,
   input  logic signed [COORD_BITS-1:0]         req_coord_x,
   input  logic signed [COORD_BITS-1:0]         req_coord_y,
   output logic                                 rsp_strobe,
   output logic                                 rsp_inside_res,
   output logic                                 rsp_on_boundary,
   output logic [pip_pkg::CROSS_W-1:0]          rsp_crossings,
   output logic                                 rsp_overflowed
);

   import pip_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DW = COORD_BITS + 2;
   localparam int PW = 2 * DW;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int VW = 2 * COORD_BITS;

   state_type state_ff, state_in;

   logic [CW-1:0]          count_ff, count_in;
   logic signed [CB-1:0]   lowest_ff, lowest_in;
   logic                   ovf_ff, ovf_in;
   logic signed [CB-1:0]   px_ff, px_in;
   logic signed [CB-1:0]   py_ff, py_in;
   logic signed [DW-1:0]   ry_ff, ry_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic signed [CB-1:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic signed [CB-1:0]   bx_ff, bx_in, by_ff, by_in;
   logic signed [CB-1:0]   fx_ff, fx_in, fy_ff, fy_in;
   logic                   last_ff, last_in;
   logic signed [PW-1:0]   p_ff, p_in;
   orient_type             ori_a_ff, ori_a_in;
   logic [CROSS_W-1:0]     cnt_ff, cnt_in;
   logic                   onb_ff, onb_in;

   logic                   accept;
   logic                   wr_en;
   logic                   rd_en;
   logic [VW-1:0]          wr_data;
   logic [VW-1:0]          rd_data;
   logic signed [CB-1:0]   rd_x, rd_y;
   logic signed [DW-1:0]   op_a, op_b;
   logic signed [PW-1:0]   prod;

   logic signed [DW-1:0]   axe, aye, bxe, bye, pxe, pye;
   orient_type             ori_b, sa, sb;
   logic                   cross_hit, onb_hit;
   logic [CW-1:0]          idx_next;

   function automatic orient_type orient_wide(input logic signed [PW-1:0] p,
                                              input logic signed [PW-1:0] q);
      orient_type r;
      if (p > q) begin
         r = ORI_POS;
      end else if (p < q) begin
         r = ORI_NEG;
      end else begin
         r = ORI_ZERO;
      end
      return r;
   endfunction

   function automatic orient_type orient_coord(input logic signed [CB-1:0] v,
                                               input logic signed [CB-1:0] ref_v);
      orient_type r;
      if (v > ref_v) begin
         r = ORI_POS;
      end else if (v < ref_v) begin
         r = ORI_NEG;
      end else begin
         r = ORI_ZERO;
      end
      return r;
   endfunction

   function automatic logic between(input logic signed [DW-1:0] v,
                                    input logic signed [DW-1:0] a,
                                    input logic signed [DW-1:0] b);
      return ((v <= a) && (v >= b)) || ((v >= a) && (v <= b));
   endfunction

   assign accept  = start && !busy;
   assign wr_data = {req_coord_x, req_coord_y};
   assign rd_x    = rd_data[VW-1:CB];
   assign rd_y    = rd_data[CB-1:0];

   pip_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_VERTICES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   pip_mul #(
      .W (DW)
   ) u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign axe = DW'(ax_ff);
   assign aye = DW'(ay_ff);
   assign bxe = DW'(bx_ff);
   assign bye = DW'(by_ff);
   assign pxe = DW'(px_ff);
   assign pye = DW'(py_ff);

   assign ori_b = orient_wide(p_ff, prod);
   assign sa    = orient_coord(ax_ff, px_ff);
   assign sb    = orient_coord(bx_ff, px_ff);

   assign cross_hit =
      ((ori_a_ff != ori_b) && (ry_ff != pye) && (sa != sb)) ||
      ((ori_a_ff == ORI_ZERO) && between(pxe, axe, bxe) && between(pye, aye, bye)) ||
      ((ori_b == ORI_ZERO) && between(pxe, axe, bxe) && between(ry_ff, aye, bye)) ||
      ((axe == pxe) && between(aye, pye, ry_ff)) ||
      ((bxe == pxe) && between(bye, pye, ry_ff));

   assign onb_hit =
      ((px_ff == ax_ff) && (py_ff == ay_ff)) ||
      ((px_ff == bx_ff) && (py_ff == by_ff)) ||
      ((ax_ff == bx_ff) && (px_ff == ax_ff) && between(pye, aye, bye)) ||
      ((ay_ff == by_ff) && (py_ff == ay_ff) && between(pxe, axe, bxe));

   assign idx_next = idx_ff + CW'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACT_QUERY)) begin
               state_in = (count_ff == '0) ? ST_DONE : ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if ((idx_ff == '0) && (count_ff != CW'(1))) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            state_in = ST_MUL_QA;
         end
         ST_MUL_QA: begin
            state_in = ST_MUL_QB;
         end
         ST_MUL_QB: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (last_ff) begin
               state_in = ST_DONE;
            end else if (idx_next == count_ff) begin
               state_in = ST_MUL_P;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      op_a       = '0;
      op_b       = '0;
      case (state_ff)
         ST_IDLE: begin
            busy  = 1'b0;
            wr_en = accept && (req_action == ACT_APPEND) &&
                    (count_ff < CW'(MAX_VERTICES));
         end
         ST_FETCH: begin
            rd_en = 1'b1;
         end
         ST_MUL_P: begin
            op_a = bye - aye;
            op_b = pxe - bxe;
         end
         ST_MUL_QA: begin
            op_a = bxe - axe;
            op_b = pye - bye;
         end
         ST_MUL_QB: begin
            op_a = bxe - axe;
            op_b = ry_ff - bye;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      lowest_in = lowest_ff;
      ovf_in    = ovf_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      ry_in     = ry_ff;
      idx_in    = idx_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      fx_in     = fx_ff;
      fy_in     = fy_ff;
      last_in   = last_ff;
      p_in      = p_ff;
      ori_a_in  = ori_a_ff;
      cnt_in    = cnt_ff;
      onb_in    = onb_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_CLEAR: begin
                     count_in  = '0;
                     lowest_in = '0;
                     ovf_in    = 1'b0;
                  end
                  ACT_APPEND: begin
                     if (count_ff < CW'(MAX_VERTICES)) begin
                        count_in = count_ff + CW'(1);
                        if ((count_ff == '0) || (req_coord_y < lowest_ff)) begin
                           lowest_in = req_coord_y;
                        end
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  ACT_QUERY: begin
                     px_in   = req_coord_x;
                     py_in   = req_coord_y;
                     ry_in   = DW'(lowest_ff) - DW'(RAY_MARGIN);
                     idx_in  = '0;
                     last_in = 1'b0;
                     cnt_in  = '0;
                     onb_in  = 1'b0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            if (idx_ff == '0) begin
               ax_in = rd_x;
               ay_in = rd_y;
               fx_in = rd_x;
               fy_in = rd_y;
               if (count_ff == CW'(1)) begin
                  bx_in   = rd_x;
                  by_in   = rd_y;
                  last_in = 1'b1;
               end else begin
                  idx_in = CW'(1);
               end
            end else begin
               bx_in = rd_x;
               by_in = rd_y;
            end
         end
         ST_MUL_QB: begin
            p_in = prod;
         end
         ST_WAIT: begin
            ori_a_in = orient_wide(p_ff, prod);
         end
         ST_EVAL: begin
            if (cross_hit && (count_ff > CW'(1))) begin
               cnt_in = cnt_ff + CROSS_W'(1);
            end
            if (onb_hit) begin
               onb_in = 1'b1;
            end
            ax_in = bx_ff;
            ay_in = by_ff;
            if (!last_ff) begin
               idx_in = idx_next;
               if (idx_next == count_ff) begin
                  bx_in   = fx_ff;
                  by_in   = fy_ff;
                  last_in = 1'b1;
               end
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         lowest_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         lowest_ff <= lowest_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      ry_ff    <= ry_in;
      idx_ff   <= idx_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      bx_ff    <= bx_in;
      by_ff    <= by_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      last_ff  <= last_in;
      p_ff     <= p_in;
      ori_a_ff <= ori_a_in;
      cnt_ff   <= cnt_in;
      onb_ff   <= onb_in;
   end

   assign rsp_inside_res  = cnt_ff[0];
   assign rsp_on_boundary = onb_ff;
   assign rsp_crossings   = cnt_ff;
   assign rsp_overflowed  = ovf_ff;

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VERTICES))
      else $error("vertex count exceeds the store depth");

   a_query_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_QUERY)) |=> busy)
      else $error("query item did not start the edge walk");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result strobe not followed by an idle cycle");

   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_en)
      else $error("vertex store written during a query");
`endif

endmodule
